// File: hw/rtl/sha_pkg.sv
// Shared types and constants for the SHA-256 stream hasher.
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } state_t;

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [5:0] LENGTH_AT = 6'd56;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// File: hw/rtl/sha_round.sv
// One SHA-256 round with on-the-fly message schedule, shared by all 64 rounds.
module sha_round (
    input  logic [31:0] v_in [8],
    input  logic [31:0] w_in [16],
    input  logic [5:0]  round,
    output logic [31:0] v_out [8],
    output logic [31:0] w_out [16]
);
    logic [31:0] t1, t2, s0, s1, wn, wr;

    always_comb
    begin
        // schedule word: window slot 0 holds w[i]
        wr = w_in[0];
        s0 = sha_pkg::rotr(w_in[1], 7) ^ sha_pkg::rotr(w_in[1], 18) ^ (w_in[1] >> 3);
        s1 = sha_pkg::rotr(w_in[14], 17) ^ sha_pkg::rotr(w_in[14], 19) ^ (w_in[14] >> 10);
        wn = w_in[0] + s0 + w_in[9] + s1;
        for (int i = 0; i < 15; i++)
        begin
            w_out[i] = w_in[i + 1];
        end
        w_out[15] = wn;
        t1 = v_in[7] + (sha_pkg::rotr(v_in[4], 6) ^ sha_pkg::rotr(v_in[4], 11)
             ^ sha_pkg::rotr(v_in[4], 25)) + ((v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6]))
             + sha_pkg::ROUND_K[round] + wr;
        t2 = (sha_pkg::rotr(v_in[0], 2) ^ sha_pkg::rotr(v_in[0], 13)
             ^ sha_pkg::rotr(v_in[0], 22))
             + ((v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]));
        v_out[7] = v_in[6];
        v_out[6] = v_in[5];
        v_out[5] = v_in[4];
        v_out[4] = v_in[3] + t1;
        v_out[3] = v_in[2];
        v_out[2] = v_in[1];
        v_out[1] = v_in[0];
        v_out[0] = t1 + t2;
    end
endmodule

// File: hw/rtl/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: byte intake, padding, rounds, digest output.
//
// Input channel s_axis: one request per message byte (tuser = mode 0) or a
// finish request (tuser = 1). tdata carries the byte.
// Output channel m_axis: eight digest words, most significant first;
// tuser carries the word index, tlast marks the eighth word.
// The 64th data byte of a block starts the 64-round compression: one round
// per cycle through the shared round unit, then an add into the hash.
// A finish request takes one padding pass (up to 64 pad bytes), one or two
// compressions, then eight digest words gated by m_axis_tready.
// s_axis_tready is low whenever the sequencer is not idle; a stalled receiver
// holds the current digest word and the block takes nothing meanwhile.
// Reset loads the standard initial hash and clears the byte counts; the byte
// window is not cleared, since padding writes every byte that gets read.
module sha256_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast    // last_word
);
    sha_pkg::state_t state_reg, state_next;

    logic [31:0] hash_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [31:0] v_rnd [8];
    logic [31:0] w_rnd [16];
    logic [5:0]  fill_reg;
    logic [54:0] blocks_reg;    // full-block count; message bits = blocks*512 + fill*8
    logic [5:0]  round_reg;
    logic [2:0]  idx_reg;
    logic        fin_reg;       // compression belongs to a finish
    logic        len_blk_reg;   // length field goes in the block being padded
    logic [63:0] bits_reg;

    logic        acc;
    logic        wr_en;
    logic [5:0]  wr_addr;
    logic [7:0]  wr_data;
    logic        start_cmp;

    assign acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == sha_pkg::ST_IDLE);
    assign m_axis_tvalid = (state_reg == sha_pkg::ST_EMIT);
    assign m_axis_tdata  = hash_reg[idx_reg];
    assign m_axis_tuser  = idx_reg;
    assign m_axis_tlast  = (idx_reg == 3'd7);

    sha_round u_round (
        .v_in  (v_reg),
        .w_in  (w_reg),
        .round (round_reg),
        .v_out (v_rnd),
        .w_out (w_rnd)
    );

    // padding byte for the current fill position
    logic [7:0] pad_byte;
    always_comb
    begin
        if (len_blk_reg && fill_reg >= sha_pkg::LENGTH_AT)
        begin
            pad_byte = bits_reg[{~fill_reg[2:0], 3'b000} +: 8];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        wr_en      = 1'b0;
        wr_addr    = fill_reg;
        wr_data    = s_axis_tdata;
        start_cmp  = 1'b0;
        case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (acc)
                begin
                    wr_en = 1'b1;
                    if (s_axis_tuser)
                    begin
                        wr_data = sha_pkg::PAD_MARK;
                        if (fill_reg == 6'd63)
                        begin
                            start_cmp  = 1'b1;
                            state_next = sha_pkg::ST_ROUND;
                        end
                        else
                        begin
                            state_next = sha_pkg::ST_PAD;
                        end
                    end
                    else if (fill_reg == 6'd63)
                    begin
                        start_cmp  = 1'b1;
                        state_next = sha_pkg::ST_ROUND;
                    end
                end
            end
            sha_pkg::ST_PAD:
            begin
                wr_en   = 1'b1;
                wr_data = pad_byte;
                if (fill_reg == 6'd63)
                begin
                    start_cmp  = 1'b1;
                    state_next = sha_pkg::ST_ROUND;
                end
            end
            sha_pkg::ST_ROUND:
            begin
                if (round_reg == 6'd63)
                begin
                    state_next = sha_pkg::ST_ADD;
                end
            end
            sha_pkg::ST_ADD:
            begin
                if (!fin_reg)
                begin
                    state_next = sha_pkg::ST_IDLE;
                end
                else if (len_blk_reg)
                begin
                    state_next = sha_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = sha_pkg::ST_PAD;
                end
            end
            sha_pkg::ST_EMIT:
            begin
                if (m_axis_tready && idx_reg == 3'd7)
                begin
                    state_next = sha_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sha_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sha_pkg::ST_IDLE;
            fill_reg    <= '0;
            blocks_reg  <= '0;
            round_reg   <= '0;
            idx_reg     <= '0;
            fin_reg     <= 1'b0;
            len_blk_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= sha_pkg::INIT_HASH[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                fill_reg <= fill_reg + 6'd1;
                // bytes fill the schedule window big-endian within each word
                w_reg[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_data;
            end
            if (acc && s_axis_tuser)
            begin
                fin_reg     <= 1'b1;
                // length fits when the marker lands before the length field
                len_blk_reg <= (fill_reg < sha_pkg::LENGTH_AT);
                bits_reg    <= {blocks_reg, fill_reg, 3'b000};
            end
            if (acc && !s_axis_tuser && fill_reg == 6'd63)
            begin
                blocks_reg <= blocks_reg + 55'd1;
            end
            if (start_cmp)
            begin
                round_reg <= '0;
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= hash_reg[i];
                end
            end
            else if (state_reg == sha_pkg::ST_ROUND)
            begin
                round_reg <= round_reg + 6'd1;
                v_reg     <= v_rnd;
                w_reg     <= w_rnd;
            end
            if (state_reg == sha_pkg::ST_ADD)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= hash_reg[i] + v_reg[i];
                end
                if (fin_reg && !len_blk_reg)
                begin
                    // second pass writes zeros then the length
                    len_blk_reg <= 1'b1;
                end
                idx_reg <= '0;
            end
            if (state_reg == sha_pkg::ST_EMIT && m_axis_tready)
            begin
                idx_reg <= idx_reg + 3'd1;
                if (idx_reg == 3'd7)
                begin
                    fin_reg    <= 1'b0;
                    blocks_reg <= '0;
                    fill_reg   <= '0;
                    for (int i = 0; i < 8; i++)
                    begin
                        hash_reg[i] <= sha_pkg::INIT_HASH[i];
                    end
                end
            end
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid) else $error("ready while emitting");
    a_round_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha_pkg::ST_ROUND && round_reg != 6'd63)
        |=> state_reg == sha_pkg::ST_ROUND) else $error("round loop cut short");
    a_emit_fin: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> fin_reg && len_blk_reg) else $error("digest before padding");
    a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(idx_reg)) else $error("index moved");
endmodule
